// ===== hw/rtl/clre_pkg.sv =====
package clre_pkg;

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic shift_right;  // add: each cell takes its left neighbor
    logic shift_left;   // remove: each cell takes its right neighbor
    logic rotate;       // advance: shift left, last held cell takes the front
  } cell_cmd_t;

endpackage

// ===== hw/rtl/clre_if.sv =====
interface clre_in_if #(
  parameter int ELEM_WIDTH = 32
);
  import clre_pkg::*;

  logic                  valid;
  logic                  ready;
  op_t                   operation;
  logic [ELEM_WIDTH-1:0] element;

  modport source (output valid, output operation, output element, input ready);
  modport sink   (input valid, input operation, input element, output ready);
endinterface

interface clre_out_if #(
  parameter int ELEM_WIDTH = 32,
  parameter int CNT_W      = 5
);
  import clre_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ELEM_WIDTH-1:0] front_element;
  logic [ELEM_WIDTH-1:0] back_element;
  logic [CNT_W-1:0]      element_count;
  logic                  is_empty;
  status_t               status;

  modport source (output valid, output front_element, output back_element,
                  output element_count, output is_empty, output status, input ready);
  modport sink   (input valid, input front_element, input back_element,
                  input element_count, input is_empty, input status, output ready);
endinterface

// ===== hw/rtl/clre_cell.sv =====
module clre_cell
  import clre_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [IDX_W-1:0]      last_idx,
  input  logic [ELEM_WIDTH-1:0] left_data,
  input  logic [ELEM_WIDTH-1:0] right_data,
  input  logic [ELEM_WIDTH-1:0] front_data,
  output logic [ELEM_WIDTH-1:0] data_out
);

  logic [ELEM_WIDTH-1:0] data_r;
  logic [ELEM_WIDTH-1:0] data_nxt;
  logic                  is_last;

  assign is_last = (last_idx == IDX_W'(IDX));

  // Pick the neighbor this cell copies from
  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_right) begin
      data_nxt = left_data;
    end else if (cmd.shift_left) begin
      data_nxt = right_data;
    end else if (cmd.rotate) begin
      data_nxt = is_last ? front_data : right_data;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

// ===== hw/rtl/circular_list_ring_engine_core.sv =====
// Latency: a request's result is registered and shown on the cycle after it is accepted.
// Throughput: one request per cycle unless out_ch stalls; the whole row moves in one step.
// A new request is taken while the previous result is being taken on the same edge.
// Reset (rst_n low, synchronous): ring empty, count zero, no result pending.
// Cell contents are not reset; only held cells are ever reported.
module circular_list_ring_engine_core
  import clre_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  clre_in_if.sink     in_ch,
  clre_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [ELEM_WIDTH-1:0] back_r;
  logic [ELEM_WIDTH-1:0] back_nxt;
  logic [ELEM_WIDTH-1:0] front_nxt;
  logic                  out_valid_r;
  logic [ELEM_WIDTH-1:0] out_front_r;
  logic [ELEM_WIDTH-1:0] out_back_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  out_empty_r;
  status_t               out_status_r;
  status_t               status_nxt;
  cell_cmd_t             cmd;
  logic                  accept;
  logic                  empty;
  logic                  full;
  logic [CNT_W-1:0]      count_m1;
  logic [IDX_W-1:0]      last_idx;
  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];

  assign accept   = in_ch.valid && in_ch.ready;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign count_m1 = count_r - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];

  // Decode the request into a row command, the new count, back and front words and the status
  always_comb begin
    cmd        = '0;
    count_nxt  = count_r;
    back_nxt   = back_r;
    front_nxt  = cell_data[0];
    status_nxt = ST_OK;
    case (in_ch.operation)
      OP_ADD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.shift_right = accept;
          count_nxt       = count_r + CNT_W'(1);
          front_nxt       = in_ch.element;
          if (empty) back_nxt = in_ch.element;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.shift_left = accept;
          count_nxt      = count_m1;
          front_nxt      = cell_data[1];
        end
      end
      OP_ADVANCE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.rotate = accept;
          back_nxt   = cell_data[0];
          front_nxt  = (last_idx == '0) ? cell_data[0] : cell_data[1];
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Row of cells, cell 0 holds the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_w;
    logic [ELEM_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = in_ch.element;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    clre_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .IDX_W      (IDX_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .last_idx   (last_idx),
      .left_data  (left_w),
      .right_data (right_w),
      .front_data (cell_data[0]),
      .data_out   (cell_data[i])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Back word and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      back_r       <= back_nxt;
      out_front_r  <= (count_nxt == '0) ? '0 : front_nxt;
      out_back_r   <= (count_nxt == '0) ? '0 : back_nxt;
      out_count_r  <= count_nxt;
      out_empty_r  <= (count_nxt == '0);
      out_status_r <= status_nxt;
    end
  end

  assign in_ch.ready          = !out_valid_r || out_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.front_element = out_front_r;
  assign out_ch.back_element  = out_back_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.is_empty      = out_empty_r;
  assign out_ch.status        = out_status_r;

endmodule

// ===== tb/ring_checker.sv =====
module ring_checker
  import clre_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  clre_in_if   in_mon,
  clre_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   checked_count,
  output int   full_rejects,
  output int   empty_rejects,
  output int   peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  // One reported view of the ring
  typedef struct packed {
    logic [31:0] front;
    logic [31:0] back;
    logic [4:0]  count;
    logic        empty;
    status_t     status;
  } ring_view_t;

  // Ring contents in order, front first, back last
  logic [31:0] ring_q[$];
  ring_view_t  view_q[$];

  // Apply one request to the ring and return what the block should show after it
  function automatic ring_view_t apply_request(op_t op, logic [31:0] elem);
    ring_view_t v;
    v.status = ST_OK;
    case (op)
      OP_ADD: begin
        if (ring_q.size() >= DEPTH) v.status = ST_FULL;
        else ring_q.push_front(elem);
      end
      OP_REMOVE: begin
        if (ring_q.size() == 0) v.status = ST_EMPTY;
        else void'(ring_q.pop_front());
      end
      OP_ADVANCE: begin
        if (ring_q.size() == 0) v.status = ST_EMPTY;
        else ring_q.push_back(ring_q.pop_front());
      end
      default: ;
    endcase
    v.count = 5'(ring_q.size());
    v.empty = (ring_q.size() == 0);
    v.front = v.empty ? 32'd0 : ring_q[0];
    v.back  = v.empty ? 32'd0 : ring_q[$];
    return v;
  endfunction

  always @(posedge clk) begin
    ring_view_t exp_v;
    ring_view_t act_v;
    logic       bad;
    if (!rst_n) begin
      ring_q.delete();
      view_q.delete();
      fail_count    = 0;
      checked_count = 0;
      full_rejects  = 0;
      empty_rejects = 0;
      peak_fill     = 0;
    end else begin
      // results first: a request's own result cannot appear on its accept edge
      if (out_mon.valid && out_mon.ready) begin
        act_v = '{out_mon.front_element, out_mon.back_element, out_mon.element_count,
                  out_mon.is_empty, out_mon.status};
        if (view_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected: front=%h back=%h count=%0d",
                   $time, act_v.front, act_v.back, act_v.count);
        end else begin
          exp_v = view_q.pop_front();
          bad = 1'b0;
          if (act_v.front !== exp_v.front) begin
            bad = 1'b1;
            $display("%0t: front_element expected %h actual %h",
                     $time, exp_v.front, act_v.front);
          end
          if (act_v.back !== exp_v.back) begin
            bad = 1'b1;
            $display("%0t: back_element expected %h actual %h",
                     $time, exp_v.back, act_v.back);
          end
          if (act_v.count !== exp_v.count) begin
            bad = 1'b1;
            $display("%0t: element_count expected %0d actual %0d",
                     $time, exp_v.count, act_v.count);
          end
          if (act_v.empty !== exp_v.empty) begin
            bad = 1'b1;
            $display("%0t: is_empty expected %b actual %b",
                     $time, exp_v.empty, act_v.empty);
          end
          if (act_v.status !== exp_v.status) begin
            bad = 1'b1;
            $display("%0t: status expected %0d actual %0d",
                     $time, exp_v.status, act_v.status);
          end
          if (bad) fail_count++;
          checked_count++;
        end
      end
      // new request: predict and queue its view
      if (in_mon.valid && in_mon.ready) begin
        exp_v = apply_request(in_mon.operation, in_mon.element);
        if (exp_v.status == ST_FULL) full_rejects++;
        if (exp_v.status == ST_EMPTY) empty_rejects++;
        if (int'(exp_v.count) > peak_fill) peak_fill = int'(exp_v.count);
        view_q.push_back(exp_v);
      end
    end
    pending = view_q.size();
  end

endmodule

// ===== tb/circular_list_ring_engine_core_tb.sv =====
module circular_list_ring_engine_core_tb;
  import clre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int RAND_ITEMS = 558;
  localparam int LIMIT      = 400000;

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_idle;
  int   cycles;
  int   sent;

  int fail_count;
  int pending;
  int checked_count;
  int full_rejects;
  int empty_rejects;
  int peak_fill;

  clre_in_if  #(.ELEM_WIDTH(32))              in_ch ();
  clre_out_if #(.ELEM_WIDTH(32), .CNT_W(5))   out_ch ();

  circular_list_ring_engine_core #(
    .DEPTH     (DEPTH),
    .ELEM_WIDTH(32)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  ring_checker #(.DEPTH(DEPTH)) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_count(checked_count),
    .full_rejects (full_rejects),
    .empty_rejects(empty_rejects),
    .peak_fill    (peak_fill)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // drive one request and hold it until accepted
  task automatic send_req(op_t op, logic [31:0] elem);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.element   <= elem;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // hold the request side until every queued result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // op mix per mode: fill, drain, or balanced
  function automatic op_t pick_op(int mode);
    int r;
    r = $urandom_range(99);
    if (r < 5) return OP_NONE;
    case (mode)
      0:       return (r < 70) ? OP_ADD : (r < 85) ? OP_REMOVE : OP_ADVANCE;
      1:       return (r < 20) ? OP_ADD : (r < 80) ? OP_REMOVE : OP_ADVANCE;
      default: return (r < 40) ? OP_ADD : (r < 70) ? OP_REMOVE : OP_ADVANCE;
    endcase
  endfunction

  function automatic logic [31:0] pick_elem();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // directed opening: empty-ring errors, extremes, fill to full, full-ring error
  task automatic run_directed();
    send_req(OP_REMOVE, 32'h0);
    send_req(OP_ADVANCE, 32'hFFFF_FFFF);
    send_req(OP_NONE, 32'h1234_5678);
    send_req(OP_ADD, 32'h0000_0000);
    send_req(OP_ADVANCE, 32'h0);      // single element rotates onto itself
    send_req(OP_REMOVE, 32'h0);       // back to empty
    send_req(OP_ADD, 32'hFFFF_FFFF);
    send_req(OP_ADD, 32'h0000_0000);
    send_req(OP_ADD, 32'hAAAA_5555);
    send_req(OP_ADD, 32'h5555_AAAA);
    send_req(OP_ADD, 32'h8000_0001);
    for (int i = 0; i < 11; i++) send_req(OP_ADD, 32'h0101_0000 + i);
    send_req(OP_ADD, 32'hDEAD_0001);  // ring is full: rejected
    send_req(OP_ADVANCE, 32'h0);      // rotate a full ring
    send_req(OP_NONE, 32'hFFFF_FFFF);
    send_req(OP_REMOVE, 32'h0);
  endtask

  initial begin
    int mode;
    int seg_left;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_ADD;
    in_ch.element   = '0;
    send_idle       = 0;
    recv_idle       = 0;
    sent            = 0;
    mode            = 2;
    seg_left        = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle = 26; recv_idle = 70; end
        1:       begin send_idle = 70; recv_idle = 26; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      drain_results();
      if (phase == 0) run_directed();
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (seg_left == 0) begin
          mode     = $urandom_range(2);
          seg_left = $urandom_range(40, 8);
        end
        seg_left--;
        send_req(pick_op(mode), pick_elem());
      end
    end

    // wind down
    drain_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests, checked %0d results over three backpressure phases.",
             sent, checked_count);
    $display("Full-ring rejects %0d, empty-ring rejects %0d, peak fill %0d of %0d.",
             full_rejects, empty_rejects, peak_fill, DEPTH);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/clre_pkg.sv
hw/rtl/clre_if.sv
hw/rtl/clre_cell.sv
hw/rtl/circular_list_ring_engine_core.sv
tb/ring_checker.sv
tb/circular_list_ring_engine_core_tb.sv
